// ===== rtl/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, widths and constants for the vertex rotate/project pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

    // Fixed-point formats
    localparam int COORD_FRAC_BITS = 12;
    localparam int TRIG_FRAC_BITS  = 14;

    // Port widths
    localparam int COORD_W   = 16;
    localparam int TRIG_W    = 16;
    localparam int DIM_W     = 13;
    localparam int OUT_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 3;

    // Internal datapath widths
    localparam int PROD_W = COORD_W + TRIG_W;      // x*c style products
    localparam int ROT_W  = PROD_W + 2;            // rotated x', y', z'
    localparam int SUM_W  = ROT_W + 1;             // x'+z', z'-y'
    localparam int NUM_W  = SUM_W + DIM_W;         // scaled numerators
    localparam int DEN_W  = ROT_W + 1;             // |2*z'|
    localparam int QUO_W  = OUT_W + 1;             // quotient magnitude bits
    localparam int CMP_W  = DEN_W + QUO_W;         // divider compare width

    // Pipeline depth: five front stages, divider, output register
    localparam int FRONT_STAGES = 5;
    localparam int DIV_STAGES   = QUO_W + 2;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + 1;

    // Register reset values
    localparam logic [TRIG_W-1:0]  COS_RESET  = TRIG_W'(1 << TRIG_FRAC_BITS);
    localparam logic [TRIG_W-1:0]  SIN_RESET  = '0;
    localparam logic [COORD_W-1:0] ZOFF_RESET = COORD_W'(1 << (COORD_FRAC_BITS + 1));
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(800);
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(600);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_ANGLE     = 3'd0,
        REG_SIN_ANGLE     = 3'd1,
        REG_Z_OFFSET      = 3'd2,
        REG_SCREEN_WIDTH  = 3'd3,
        REG_SCREEN_HEIGHT = 3'd4
    } cfg_idx_t;

    // Depth status carried alongside each word
    typedef struct packed {
        logic zero;     // z' == 0
        logic bad;      // z' <= 0
    } depth_flag_t;

endpackage

// ===== rtl/vrp_div.sv =====
// ----------------------------------------------------------------------------
// vrp_div
// Pipelined restoring divider, one quotient bit per stage, with signed
// saturation of the truncated quotient to the output width.
// ----------------------------------------------------------------------------
module vrp_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [vrp_pkg::NUM_W-1:0]   num,
    input  logic [vrp_pkg::DEN_W-1:0]   den,
    input  logic                        neg,
    output logic signed [vrp_pkg::OUT_W-1:0] quo
);
    import vrp_pkg::*;

    localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1 << (OUT_W - 1));

    logic [NUM_W-1:0] rem_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             neg_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];
    logic signed [OUT_W-1:0] sat_reg;
    logic signed [OUT_W-1:0] sat_next;

    // Entry: quotient would need more than QUO_W bits (also catches den == 0)
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (CMP_W'(num) >= {den, {QUO_W{1'b0}}});
        end
    end

    // One quotient bit per stage, MSB first
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int SH = QUO_W - 1 - k;
        logic [CMP_W-1:0] rem_ext;
        logic [CMP_W-1:0] den_sh;
        logic [CMP_W-1:0] diff;
        logic             take;

        assign rem_ext = CMP_W'(rem_reg[k]);
        assign den_sh  = CMP_W'(den_reg[k]) << SH;
        assign diff    = rem_ext - den_sh;
        assign take    = (rem_ext >= den_sh);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? diff[NUM_W-1:0] : rem_reg[k];
                quo_reg[k+1] <= quo_reg[k] | ({{(QUO_W-1){1'b0}}, take} << SH);
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // Apply sign and clamp to the signed output range
    always_comb begin
        if (!neg_reg[QUO_W]) begin
            if (ovf_reg[QUO_W] || (quo_reg[QUO_W] > POS_LIMIT)) begin
                sat_next = OUT_W'(POS_LIMIT);
            end else begin
                sat_next = quo_reg[QUO_W][OUT_W-1:0];
            end
        end else begin
            if (ovf_reg[QUO_W] || (quo_reg[QUO_W] > NEG_LIMIT)) begin
                sat_next = OUT_W'(NEG_LIMIT);
            end else begin
                sat_next = OUT_W'(-quo_reg[QUO_W]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg <= sat_next;
        end
    end

    assign quo = sat_reg;

endmodule

// ===== rtl/vertex_rotate_project_unit.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_unit
// Rotates a Q3.12 vertex about the vertical axis, adds a depth offset,
// divides by depth and maps the point to saturated pixel coordinates.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not held; the 17-stage
//   bit-per-stage divider pair sets the depth, and the whole pipeline freezes
//   while a valid output word waits with m_ready low.
// Reset: valid bits clear at once and the configuration registers return to
//   their defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module vertex_rotate_project_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]       cfg_wr_idx,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]      cfg_wr_data,

    // Input vertex channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [vrp_pkg::COORD_W-1:0]  s_vertex_x,
    input  logic signed [vrp_pkg::COORD_W-1:0]  s_vertex_y,
    input  logic signed [vrp_pkg::COORD_W-1:0]  s_vertex_z,

    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vrp_pkg::OUT_W-1:0]    m_screen_x,
    output logic signed [vrp_pkg::OUT_W-1:0]    m_screen_y,
    output logic                                m_depth_invalid
);
    import vrp_pkg::*;

    localparam int Y_PAD    = ROT_W - COORD_W - TRIG_FRAC_BITS;
    localparam int FLAG_DEPTH = PIPE_DEPTH - 3;

    // Configuration registers
    logic signed [TRIG_W-1:0]  cos_reg;
    logic signed [TRIG_W-1:0]  sin_reg;
    logic signed [COORD_W-1:0] zoff_reg;
    logic [DIM_W-1:0]          width_reg;
    logic [DIM_W-1:0]          height_reg;

    // Handshake and valid line
    logic                      adv;
    logic [PIPE_DEPTH-1:0]     pipe_valid_reg;
    logic [PIPE_DEPTH-1:0]     pipe_valid_next;
    depth_flag_t               flag_reg [0:FLAG_DEPTH-1];

    // Stage 1: products
    logic signed [PROD_W-1:0]  xc_reg, zs_reg, xs_reg, zc_reg;
    logic signed [COORD_W-1:0] y1_reg;
    // Stage 2: rotation
    logic signed [ROT_W-1:0]   rx_reg, ry_reg, rz_reg;
    logic signed [ROT_W-1:0]   zoff_ext;
    logic signed [ROT_W-1:0]   y_ext;
    // Stage 3: numerator sums
    logic signed [SUM_W-1:0]   ax_reg, by_reg;
    logic signed [ROT_W-1:0]   rz3_reg;
    // Stage 4: scaled numerators, depth magnitude
    logic signed [NUM_W-1:0]   nx_reg, ny_reg;
    logic signed [NUM_W-1:0]   nx_next, ny_next;
    logic [ROT_W-1:0]          rz_mag;
    logic [DEN_W-1:0]          den4_reg;
    logic                      dneg4_reg;
    // Stage 5: magnitudes and result signs
    logic [NUM_W-1:0]          magx_reg, magy_reg;
    logic [DEN_W-1:0]          den5_reg;
    logic                      negx_reg, negy_reg;
    // Divider outputs and result register
    logic signed [OUT_W-1:0]   qx, qy;
    logic signed [OUT_W-1:0]   m_screen_x_reg, m_screen_y_reg;
    logic                      m_depth_invalid_reg;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= COS_RESET;
            sin_reg    <= SIN_RESET;
            zoff_reg   <= ZOFF_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                REG_COS_ANGLE:     cos_reg    <= cfg_wr_data[TRIG_W-1:0];
                REG_SIN_ANGLE:     sin_reg    <= cfg_wr_data[TRIG_W-1:0];
                REG_Z_OFFSET:      zoff_reg   <= cfg_wr_data[COORD_W-1:0];
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wr_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_wr_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the whole pipe moves unless the output word is held
    assign adv     = !pipe_valid_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = adv;

    always_comb begin
        pipe_valid_next = pipe_valid_reg;
        if (adv) begin
            pipe_valid_next = {pipe_valid_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= '0;
        end else begin
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    // Stage 1: rotation products
    always_ff @(posedge aclk) begin
        if (adv) begin
            xc_reg <= s_vertex_x * cos_reg;
            zs_reg <= s_vertex_z * sin_reg;
            xs_reg <= s_vertex_x * sin_reg;
            zc_reg <= s_vertex_z * cos_reg;
            y1_reg <= s_vertex_y;
        end
    end

    // Stage 2: x', y', z' at the common product scale
    assign zoff_ext = {{Y_PAD{zoff_reg[COORD_W-1]}}, zoff_reg, {TRIG_FRAC_BITS{1'b0}}};
    assign y_ext    = {{Y_PAD{y1_reg[COORD_W-1]}}, y1_reg, {TRIG_FRAC_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (adv) begin
            rx_reg <= ROT_W'(xc_reg) - ROT_W'(zs_reg);
            rz_reg <= ROT_W'(xs_reg) + ROT_W'(zc_reg) + zoff_ext;
            ry_reg <= y_ext;
        end
    end

    // Stage 3: numerator sums and depth flags
    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg  <= SUM_W'(rx_reg) + SUM_W'(rz_reg);
            by_reg  <= SUM_W'(rz_reg) - SUM_W'(ry_reg);
            rz3_reg <= rz_reg;
            flag_reg[0].zero <= (rz_reg == '0);
            flag_reg[0].bad  <= (rz_reg == '0) || rz_reg[ROT_W-1];
        end
    end

    // Flags ride along to the output stage
    for (genvar j = 1; j < FLAG_DEPTH; j++) begin : g_flag
        always_ff @(posedge aclk) begin
            if (adv) begin
                flag_reg[j] <= flag_reg[j-1];
            end
        end
    end

    // Stage 4: scale by raster size, form |2*z'|
    assign nx_next = ax_reg * $signed({1'b0, width_reg});
    assign ny_next = by_reg * $signed({1'b0, height_reg});
    assign rz_mag  = rz3_reg[ROT_W-1] ? ROT_W'(-rz3_reg) : ROT_W'(rz3_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            den4_reg  <= {rz_mag, 1'b0};
            dneg4_reg <= rz3_reg[ROT_W-1];
        end
    end

    // Stage 5: unsigned magnitudes and quotient signs
    always_ff @(posedge aclk) begin
        if (adv) begin
            magx_reg <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
            magy_reg <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
            negx_reg <= nx_reg[NUM_W-1] ^ dneg4_reg;
            negy_reg <= ny_reg[NUM_W-1] ^ dneg4_reg;
            den5_reg <= den4_reg;
        end
    end

    // Divider lanes for x and y share the depth
    vrp_div u_div_x (
        .aclk (aclk),
        .en   (adv),
        .num  (magx_reg),
        .den  (den5_reg),
        .neg  (negx_reg),
        .quo  (qx)
    );

    vrp_div u_div_y (
        .aclk (aclk),
        .en   (adv),
        .num  (magy_reg),
        .den  (den5_reg),
        .neg  (negy_reg),
        .quo  (qy)
    );

    // Output register; zero depth forces both coordinates to zero
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_screen_x_reg      <= flag_reg[FLAG_DEPTH-1].zero ? '0 : qx;
            m_screen_y_reg      <= flag_reg[FLAG_DEPTH-1].zero ? '0 : qy;
            m_depth_invalid_reg <= flag_reg[FLAG_DEPTH-1].bad;
        end
    end

    assign m_valid         = pipe_valid_reg[PIPE_DEPTH-1];
    assign m_screen_x      = m_screen_x_reg;
    assign m_screen_y      = m_screen_y_reg;
    assign m_depth_invalid = m_depth_invalid_reg;

    // A held output freezes every valid bit in the pipe
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(pipe_valid_reg))
        else $error("valid line moved during stall");

    // Advancing shifts the valid line by exactly one place
    a_valid_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (pipe_valid_reg[PIPE_DEPTH-1:1] == $past(pipe_valid_reg[PIPE_DEPTH-2:0])))
        else $error("valid line lost or duplicated a word");

    // An accepted word occupies the first stage on the next edge
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> pipe_valid_reg[0])
        else $error("accepted word not captured");

    // A zero-depth word always leaves flagged with zeroed coordinates
    a_zero_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && pipe_valid_reg[PIPE_DEPTH-2] && flag_reg[FLAG_DEPTH-1].zero) |=>
        (m_depth_invalid && (m_screen_x == '0) && (m_screen_y == '0)))
        else $error("zero depth result not cleared");

endmodule

// ===== tb/sv/vrp_projection_checker.sv =====
// ----------------------------------------------------------------------------
// vrp_projection_checker
// Watches the configuration port and both word channels of the vertex
// rotate/project unit. Keeps its own copy of the registers and computes the
// expected pixel word for every accepted vertex. Each result word is compared
// field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module vrp_projection_checker (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]       cfg_wr_idx,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]      cfg_wr_data,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [vrp_pkg::COORD_W-1:0]  s_vertex_x,
    input  logic signed [vrp_pkg::COORD_W-1:0]  s_vertex_y,
    input  logic signed [vrp_pkg::COORD_W-1:0]  s_vertex_z,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [vrp_pkg::OUT_W-1:0]    m_screen_x,
    input  logic signed [vrp_pkg::OUT_W-1:0]    m_screen_y,
    input  logic                                m_depth_invalid,

    output int                                  error_count,
    output int                                  pending_count,
    output int                                  result_count,
    output int                                  bad_depth_count
);
    import vrp_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] col;
        logic signed [OUT_W-1:0] row;
        logic                    bad_depth;
    } pixel_t;

    localparam longint TRIG_ONE     = longint'(1) << TRIG_FRAC_BITS;
    localparam longint PIX_MAX      = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint PIX_MIN      = -(longint'(1) << (OUT_W - 1));

    // Register shadow, held wide so the products below never overflow
    longint cos_q;
    longint sin_q;
    longint zoff_q;
    longint width_q;
    longint height_q;

    pixel_t expected_pixels[$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     bad_depth_seen = 0;

    // Truncated quotient clamped to the output range
    function automatic logic signed [OUT_W-1:0] clamp_pixel(input longint v);
        if (v > PIX_MAX) return OUT_W'(PIX_MAX);
        if (v < PIX_MIN) return OUT_W'(PIX_MIN);
        return OUT_W'(v);
    endfunction

    // Rotate about the vertical axis, offset depth, divide and map to pixels.
    // All three rotated values share one scale, so the fraction bits cancel.
    function automatic pixel_t project_vertex(input logic signed [COORD_W-1:0] vx,
                                              input logic signed [COORD_W-1:0] vy,
                                              input logic signed [COORD_W-1:0] vz);
        longint rot_x;
        longint rot_y;
        longint depth;
        longint den;
        pixel_t p;
        rot_x = longint'(vx) * cos_q - longint'(vz) * sin_q;
        rot_y = longint'(vy) * TRIG_ONE;
        depth = longint'(vx) * sin_q + longint'(vz) * cos_q + zoff_q * TRIG_ONE;
        // zero depth: flag set, both coordinates forced to 0
        if (depth == 0) begin
            p.col       = '0;
            p.row       = '0;
            p.bad_depth = 1'b1;
            return p;
        end
        den         = 2 * depth;
        p.col       = clamp_pixel(((rot_x + depth) * width_q) / den);
        p.row       = clamp_pixel(((depth - rot_y) * height_q) / den);
        p.bad_depth = (depth < 0);
        return p;
    endfunction

    // Append an expectation at the tail of the queue
    task automatic enqueue_pixel(input pixel_t p);
        expected_pixels.insert(expected_pixels.size(), p);
    endtask

    task automatic note_mismatch(input string field, input longint want,
                                 input longint got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // Everything is sampled at the rising edge, before the drivers update
    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            cos_q    = longint'($signed(COS_RESET));
            sin_q    = longint'($signed(SIN_RESET));
            zoff_q   = longint'($signed(ZOFF_RESET));
            width_q  = longint'(WIDTH_RESET);
            height_q = longint'(HEIGHT_RESET);
            expected_pixels.delete();
        end else begin
            // result word against the oldest expectation
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected nothing, got (%0d, %0d, %0b)",
                             $time, m_screen_x, m_screen_y, m_depth_invalid);
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.bad_depth) bad_depth_seen++;
                    if (m_screen_x !== want.col)
                        note_mismatch("screen_x", want.col, m_screen_x);
                    if (m_screen_y !== want.row)
                        note_mismatch("screen_y", want.row, m_screen_y);
                    if (m_depth_invalid !== want.bad_depth)
                        note_mismatch("depth_invalid", want.bad_depth, m_depth_invalid);
                end
            end

            // vertex word: predict with the registers as they stand
            if (s_valid && s_ready)
                enqueue_pixel(project_vertex(s_vertex_x, s_vertex_y, s_vertex_z));

            // register write; unknown indexes fall through
            if (cfg_wr_en) begin
                case (cfg_wr_idx)
                    REG_COS_ANGLE:     cos_q    = longint'($signed(cfg_wr_data));
                    REG_SIN_ANGLE:     sin_q    = longint'($signed(cfg_wr_data));
                    REG_Z_OFFSET:      zoff_q   = longint'($signed(cfg_wr_data));
                    REG_SCREEN_WIDTH:  width_q  = longint'(cfg_wr_data[DIM_W-1:0]);
                    REG_SCREEN_HEIGHT: height_q = longint'(cfg_wr_data[DIM_W-1:0]);
                    default: ;
                endcase
            end
        end

        error_count     <= mismatches;
        pending_count   <= expected_pixels.size();
        result_count    <= results_seen;
        bad_depth_count <= bad_depth_seen;
    end

endmodule

// ===== tb/sv/vertex_rotate_project_unit_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_unit_tb
// Drives vertex words through the rotate/project unit under a series of
// register settings (defaults, quarter turns, half turn, extreme and out of
// range values, screen sizes of 0 and 8191) and several idle patterns,
// including one long receiver hold-off. The checker predicts every result.
// ----------------------------------------------------------------------------
module vertex_rotate_project_unit_tb;
    import vrp_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int TRIG_UNIT       = 1 << TRIG_FRAC_BITS;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_wr_idx;
    logic [CFG_DATA_W-1:0]      cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [COORD_W-1:0]  s_vertex_x;
    logic signed [COORD_W-1:0]  s_vertex_y;
    logic signed [COORD_W-1:0]  s_vertex_z;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [OUT_W-1:0]    m_screen_x;
    logic signed [OUT_W-1:0]    m_screen_y;
    logic                       m_depth_invalid;

    int error_count;
    int pending_count;
    int result_count;
    int bad_depth_count;

    int gap_pct      = 0;
    int stall_pct    = 0;
    bit hold_request = 1'b0;
    int sent_words   = 0;
    int cycle_count  = 0;

    // Current register values, used to aim vertices at zero depth
    int cur_cos  = TRIG_UNIT;
    int cur_sin  = 0;
    int cur_zoff = 1 << (COORD_FRAC_BITS + 1);

    vertex_rotate_project_unit DUT (.*);

    vrp_projection_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // One register write per cycle; the caller lowers the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Register setting per phase; phase 0 keeps the reset values
    task automatic set_phase_registers(input int p);
        int c, s, z, w, h;
        logic [CFG_DATA_W-1:0] junk;
        c = cur_cos; s = cur_sin; z = cur_zoff; w = 800; h = 600;
        case (p)
            1: begin c = 0;      s = 16384;  z = 8192;   w = 640;  h = 480;  end
            2: begin c = -16384; s = 0;      z = -8192;  w = 4096; h = 4096; end
            3: begin c = 11585;  s = 11585;  z = 12288;  w = 1;    h = 1;    end
            4: begin c = -32768; s = 32767;  z = 32767;  w = 8191; h = 0;    end
            5: begin
                c = $urandom_range(0, 32768) - 16384;
                s = $urandom_range(0, 32768) - 16384;
                z = $urandom_range(4096, 32767);
                w = $urandom_range(1, 4096);
                h = $urandom_range(1, 4096);
            end
            6: begin c = 16384;  s = -16384; z = -32768; w = 1920; h = 1080; end
            7: begin c = 0;      s = -16384; z = 0;      w = 0;    h = 8191; end
            default: ;
        endcase
        if (p != 0) begin
            junk = CFG_DATA_W'($urandom);
            write_reg(REG_COS_ANGLE, CFG_DATA_W'(c));
            write_reg(REG_SIN_ANGLE, CFG_DATA_W'(s));
            write_reg(REG_Z_OFFSET, CFG_DATA_W'(z));
            // upper bits of the size registers carry junk that must be dropped
            write_reg(REG_SCREEN_WIDTH, {junk[CFG_DATA_W-1:DIM_W], DIM_W'(w)});
            write_reg(REG_SCREEN_HEIGHT, {junk[CFG_DATA_W-1:DIM_W], DIM_W'(h)});
        end
        // writes to unused indexes are ignored
        for (int i = REG_SCREEN_HEIGHT + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        cur_cos  = 16'(c) > 16'h7FFF ? int'($signed(16'(c))) : c;
        cur_sin  = s;
        cur_zoff = z;
    endtask

    // Offer one vertex word, with random idle cycles ahead of it
    task automatic send_vertex(input int vx, input int vy, input int vz);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_vertex_x <= COORD_W'(vx);
        s_vertex_y <= COORD_W'(vy);
        s_vertex_z <= COORD_W'(vz);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_words++;
    endtask

    function automatic int extreme_coord();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // Stimulus and verdict
    initial begin
        int vx, vy, vz;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_idx  <= '0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_vertex_x  <= '0;
        s_vertex_y  <= '0;
        s_vertex_z  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_phase_registers(p);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 45; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 45; end
                default: begin gap_pct = 33; stall_pct = 33; end
            endcase

            if (p == 0) begin
                // directed words under the reset register values
                send_vertex(0, 0, 0);                   // screen center
                send_vertex(4096, 4096, 0);             // inside the frame
                send_vertex(32767, 32767, 32767);
                send_vertex(-32768, -32768, -32768);    // negative depth
                send_vertex(32767, -32768, -8191);      // clamp high
                send_vertex(-32768, 32767, -8191);      // clamp low
                send_vertex(0, 0, -8192);               // zero depth
                send_vertex(1234, -567, -8192);         // zero depth, coords forced
                send_vertex(0, 0, -16384);              // negative depth, center
                send_vertex(4096, 0, -16384);
                send_vertex(-1, -1, -1);
                send_vertex(1, 1, 1);
                send_vertex(16'h5555, 16'hAAAA, -8193);
            end

            // long hold-off: the pipeline fills and the input stalls
            if (p == 1) hold_request = 1'b1;

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        vx = $urandom;
                        vy = $urandom;
                        vz = $urandom;
                    end
                    8: begin
                        // aim at zero depth, sometimes one step off
                        vx = $urandom;
                        vy = $urandom;
                        vz = $urandom;
                        if (cur_sin == 0 && (cur_cos == TRIG_UNIT || cur_cos == -TRIG_UNIT)) begin
                            vx = 0;
                            vz = (cur_cos > 0) ? -cur_zoff : cur_zoff;
                        end else if (cur_cos == 0 && (cur_sin == TRIG_UNIT || cur_sin == -TRIG_UNIT)) begin
                            vz = 0;
                            vx = (cur_sin > 0) ? -cur_zoff : cur_zoff;
                        end
                        if ($urandom_range(0, 3) == 0) begin
                            vz = vz + $urandom_range(0, 2) - 1;
                        end
                    end
                    9: begin
                        vx = extreme_coord();
                        vy = extreme_coord();
                        vz = extreme_coord();
                    end
                    default: begin
                        // well-formed vertex near the unit cube
                        vx = $urandom_range(0, 8192) - 4096;
                        vy = $urandom_range(0, 8192) - 4096;
                        vz = $urandom_range(0, 6144) - 2048;
                    end
                endcase
                send_vertex(vx, vy, vz);
            end

            // let the phase drain before touching the registers again
            s_valid <= 1'b0;
            @(posedge aclk);
            while (pending_count != 0) @(posedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d vertex words over %0d register settings, %0d results checked, %0d with bad depth",
                 sent_words, NUM_PHASES, result_count, bad_depth_count);
        $display("summary: idle patterns none, sender gaps, receiver stalls and both, plus one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (error_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
